### rtl/core/escape_sequence_decoder_core_macros.svh
// Assertion macros shared by the escape sequence decoder RTL.
`ifndef ESCAPE_SEQUENCE_DECODER_CORE_MACROS_SVH
`define ESCAPE_SEQUENCE_DECODER_CORE_MACROS_SVH

`ifndef SYNTH
// prop must hold at every rising clock edge outside reset
`define ESD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expr must never be true outside reset
`define ESD_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ESD_ASSERT(lbl, clk, rst_n, prop, msg)
`define ESD_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

### rtl/core/esd_pkg.sv
// Shared types, character constants and lookup functions of the escape decoder.
package esd_pkg;

	localparam int unsigned MaxResults = 3;

	typedef logic [7:0] byte_t;

	// group of result bytes produced by one final character
	typedef struct packed {
		logic [1:0]                  cnt;
		logic                        bad;
		byte_t [MaxResults-1:0]      bytes;
	} grp_t;

	localparam byte_t CH_0   = 8'h30;
	localparam byte_t CH_7   = 8'h37;
	localparam byte_t CH_X   = 8'h78;
	localparam byte_t CH_U   = 8'h75;
	localparam byte_t BYTE_ESC = 8'h1B;

	// {hit, mapped byte}
	function automatic logic [8:0] simple_map(input byte_t c);
		logic [8:0] r;
		case (c)
			8'h22:   r = {1'b1, 8'h22};	// "
			8'h27:   r = {1'b1, 8'h27};	// '
			8'h3F:   r = {1'b1, 8'h3F};	// ?
			8'h74:   r = {1'b1, 8'h09};	// t
			8'h6E:   r = {1'b1, 8'h0A};	// n
			8'h72:   r = {1'b1, 8'h0D};	// r
			8'h5C:   r = {1'b1, 8'h5C};	// backslash
			8'h62:   r = {1'b1, 8'h08};	// b
			8'h66:   r = {1'b1, 8'h0C};	// f
			8'h76:   r = {1'b1, 8'h0B};	// v
			8'h61:   r = {1'b1, 8'h07};	// a
			8'h65:   r = {1'b1, BYTE_ESC};	// e
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// {valid, digit value}
	function automatic logic [4:0] hex_val(input byte_t c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, c[3:0]};
		else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			r = {1'b1, c[3:0] + 4'd9};
		return r;
	endfunction

endpackage

### rtl/core/esd_ifs.sv
// Valid/ready channel interfaces for escape body characters and decoded bytes.
interface esd_in_if;
	logic                 valid;
	logic                 ready;
	esd_pkg::byte_t       body_char;
	logic                 body_last;

	modport source (output valid, output body_char, output body_last, input ready);
	modport sink (input valid, input body_char, input body_last, output ready);
endinterface

interface esd_out_if;
	logic                 valid;
	logic                 ready;
	esd_pkg::byte_t       out_byte;
	logic                 out_last;
	logic                 bad_escape;

	modport source (output valid, output out_byte, output out_last, output bad_escape,
		input ready);
	modport sink (input valid, input out_byte, input out_last, input bad_escape,
		output ready);
endinterface

### rtl/core/esd_parse.sv
// Escape body parser: parse state registers and per-character decode logic.
module esd_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  esd_pkg::byte_t    body_char,
	input  logic              body_last,
	output esd_pkg::grp_t     grp
);

	typedef enum logic [2:0] {
		MODE_START = 3'd0,
		MODE_OCT   = 3'd1,
		MODE_HEX   = 3'd2,
		MODE_UNI   = 3'd3,
		MODE_BAD   = 3'd4
	} mode_t;

	mode_t        mode_q, mode_d;
	logic [15:0]  code_q, code_d;
	logic [2:0]   cnt_q, cnt_d;

	logic [8:0]   smap;
	logic [4:0]   hv;
	logic         is_oct;
	logic         simple_done;
	logic         surrogate;

	always_comb begin
		smap   = esd_pkg::simple_map(body_char);
		hv     = esd_pkg::hex_val(body_char);
		is_oct = (body_char >= esd_pkg::CH_0) && (body_char <= esd_pkg::CH_7);
		mode_d = mode_q;
		code_d = code_q;
		cnt_d  = cnt_q;
		simple_done = 1'b0;
		case (mode_q)
			MODE_START: begin
				if (smap[8]) begin
					simple_done = 1'b1;
					mode_d = MODE_BAD;	// anything after a simple escape is an error
				end else if (is_oct) begin
					mode_d = MODE_OCT;
					code_d = {13'd0, body_char[2:0]};
					cnt_d  = 3'd1;
				end else if (body_char == esd_pkg::CH_X) begin
					mode_d = MODE_HEX;
					code_d = 16'd0;
					cnt_d  = 3'd0;
				end else if (body_char == esd_pkg::CH_U) begin
					mode_d = MODE_UNI;
					code_d = 16'd0;
					cnt_d  = 3'd0;
				end else begin
					mode_d = MODE_BAD;
				end
			end
			MODE_OCT: begin
				if (is_oct && cnt_q < 3'd3) begin
					code_d = {code_q[12:0], body_char[2:0]};
					cnt_d  = cnt_q + 3'd1;
				end else begin
					mode_d = MODE_BAD;
				end
			end
			MODE_HEX: begin
				if (hv[4]) begin
					code_d = {code_q[11:0], hv[3:0]};
					if (cnt_q < 3'd7)
						cnt_d = cnt_q + 3'd1;
				end else begin
					mode_d = MODE_BAD;
				end
			end
			MODE_UNI: begin
				if (hv[4] && cnt_q < 3'd4) begin
					code_d = {code_q[11:0], hv[3:0]};
					cnt_d  = cnt_q + 3'd1;
				end else begin
					mode_d = MODE_BAD;
				end
			end
			default: mode_d = MODE_BAD;
		endcase
	end

	// result group, only meaningful on the final character
	always_comb begin
		surrogate = (code_d[15:11] == 5'b11011);
		grp = '0;
		if (body_last) begin
			grp.cnt = 2'd1;
			if (simple_done) begin
				grp.bytes[0] = smap[7:0];
			end else if (mode_d == MODE_OCT) begin
				grp.bytes[0] = code_d[7:0];
			end else if (mode_d == MODE_HEX && cnt_d != 3'd0) begin
				grp.bytes[0] = code_d[7:0];
			end else if (mode_d == MODE_UNI && cnt_d == 3'd4 && !surrogate) begin
				if (code_d[15:7] == 9'd0) begin
					grp.bytes[0] = code_d[7:0];
				end else if (code_d[15:11] == 5'd0) begin
					grp.cnt      = 2'd2;
					grp.bytes[0] = {3'b110, code_d[10:6]};
					grp.bytes[1] = {2'b10, code_d[5:0]};
				end else begin
					grp.cnt      = 2'd3;
					grp.bytes[0] = {4'b1110, code_d[15:12]};
					grp.bytes[1] = {2'b10, code_d[11:6]};
					grp.bytes[2] = {2'b10, code_d[5:0]};
				end
			end else begin
				grp.bad = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_START;
			code_q <= 16'd0;
			cnt_q  <= 3'd0;
		end else if (take) begin
			if (body_last) begin
				mode_q <= MODE_START;
				code_q <= 16'd0;
				cnt_q  <= 3'd0;
			end else begin
				mode_q <= mode_d;
				code_q <= code_d;
				cnt_q  <= cnt_d;
			end
		end
	end

endmodule

### rtl/core/esd_out.sv
// Result register: holds one decoded group and hands its bytes out one per request.
`include "escape_sequence_decoder_core_macros.svh"

module esd_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  esd_pkg::grp_t     grp,
	output logic              can_load,
	esd_out_if.source         dec_out
);

	logic [1:0]                                   rem_q;
	logic [1:0]                                   pos_q;
	logic                                         bad_q;
	esd_pkg::byte_t [esd_pkg::MaxResults-1:0]     bytes_q;
	logic                                         taken;

	assign taken    = (rem_q != 2'd0) && dec_out.ready;
	assign can_load = (rem_q == 2'd0) || (rem_q == 2'd1 && dec_out.ready);

	assign dec_out.valid      = (rem_q != 2'd0);
	assign dec_out.out_byte   = bytes_q[pos_q];
	assign dec_out.out_last   = (rem_q == 2'd1);
	assign dec_out.bad_escape = bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
			pos_q <= 2'd0;
		end else if (load) begin
			rem_q <= grp.cnt;
			pos_q <= 2'd0;
		end else if (taken) begin
			rem_q <= rem_q - 2'd1;
			pos_q <= pos_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= grp.bytes;
			bad_q   <= grp.bad;
		end
	end

	`ESD_NEVER(a_rem_range, clk, arst_n, rem_q == 2'd3 && pos_q != 2'd0, "group index out of step")
	`ESD_NEVER(a_no_overrun, clk, arst_n, load && !can_load, "group loaded over pending bytes")
	`ESD_ASSERT(a_bad_single, clk, arst_n, (rem_q != 2'd0 && bad_q) |-> (rem_q == 2'd1 && pos_q == 2'd0 && bytes_q[0] == 8'd0), "error result is not a single zero byte")

endmodule

### rtl/core/escape_sequence_decoder_core.sv
// Escape sequence decoder: takes the characters after a backslash, one per request,
// and on the final character emits the decoded bytes (simple escapes, 1-3 octal
// digits, 'x' + hex digits, 'u' + four hex digits as UTF-8) or one error result.
// A character is accepted every cycle unless a final character waits in the input
// register; it is registered, decoded there against the parse state, and its
// results are registered in the result register, from which the first byte leaves.
// Non-final characters produce nothing and never wait. A final character waits in
// the input register only while the result register still holds bytes that will
// not all be gone by the end of that cycle: a 'u' escape that encodes to two or
// three UTF-8 bytes occupies the result register until all of them are taken, one byte
// per output request; every other escape occupies it for a single byte.
`include "escape_sequence_decoder_core_macros.svh"

module escape_sequence_decoder_core (
	input  logic         clk,
	input  logic         arst_n,
	esd_in_if.sink       esc_in,
	esd_out_if.source    dec_out
);

	// input register
	logic                 vld_s1;
	esd_pkg::byte_t       char_s1;
	logic                 last_s1;

	esd_pkg::grp_t        grp;
	logic                 can_load;
	logic                 adv;		// item in stage 1 is consumed this cycle
	logic                 load;		// its results enter the result register

	// only a final character needs room in the result register
	assign adv  = vld_s1 && (!last_s1 || can_load);
	assign load = adv && last_s1;

	assign esc_in.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (esc_in.ready) begin
			vld_s1 <= esc_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (esc_in.valid && esc_in.ready) begin
			char_s1 <= esc_in.body_char;
			last_s1 <= esc_in.body_last;
		end
	end

	// parse state and per-character decode
	esd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (adv),
		.body_char (char_s1),
		.body_last (last_s1),
		.grp       (grp)
	);

	// result register, one byte per output request
	esd_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.grp      (grp),
		.can_load (can_load),
		.dec_out  (dec_out)
	);

	`ESD_ASSERT(a_s1_hold, clk, arst_n, (vld_s1 && !adv) |=> (vld_s1 && $stable(char_s1) && $stable(last_s1)), "stalled character lost")
	`ESD_NEVER(a_group_on_last, clk, arst_n, vld_s1 && ((grp.cnt != 2'd0) != last_s1), "result group not tied to final character")

endmodule

### verif/tb_escape_sequence_decoder_core.sv
// Self-checking testbench for the escape sequence decoder core.
`timescale 1ns / 100ps

module tb_escape_sequence_decoder_core;

	// Parse state of the scoreboard's own decoder
	typedef enum logic [2:0] {
		PARSE_START = 3'd0,
		PARSE_OCT   = 3'd1,
		PARSE_HEX   = 3'd2,
		PARSE_UNI   = 3'd3,
		PARSE_BAD   = 3'd4
	} parse_mode_t;

	// One character request waiting to be sent
	typedef struct packed {
		esd_pkg::byte_t ch;
		logic           fin;
	} body_item_t;

	// One decoded byte the block still owes us
	typedef struct packed {
		esd_pkg::byte_t data;
		logic           fin;
		logic           bad;
	} dec_byte_t;

	logic clk;
	logic arst_n;

	esd_in_if  body_ch ();
	esd_out_if dec_ch ();

	escape_sequence_decoder_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.esc_in (body_ch),
		.dec_out(dec_ch)
	);

	body_item_t     chars_to_send[$];
	dec_byte_t      bytes_due[$];
	esd_pkg::byte_t body_buf[$];

	// Decoder state mirrored from the spec
	parse_mode_t    mode_q;
	logic [15:0]    acc_q;
	logic [2:0]     ndig_q;
	esd_pkg::byte_t simple_q;

	int errors;
	int chars_taken;
	int escapes_seen;
	int multi_seen;
	int bytes_checked;
	int bad_checked;

	// Single-character escapes, in the order the spec lists them
	string simple_set = "\"'?tnr\\bfvae";

	// Full-rate window: neither side throttles here
	logic quiet;
	assign quiet = (chars_taken >= 120) && (chars_taken < 175);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	//------------------------------------------------------------------
	// Scoreboard decoder
	//------------------------------------------------------------------
	function automatic logic simple_lookup(input esd_pkg::byte_t c,
			output esd_pkg::byte_t b);
		b = 8'h00;
		case (c)
			"\"": b = 8'h22;
			"'":  b = 8'h27;
			"?":  b = 8'h3F;
			"t":  b = 8'h09;
			"n":  b = 8'h0A;
			"r":  b = 8'h0D;
			"\\": b = 8'h5C;
			"b":  b = 8'h08;
			"f":  b = 8'h0C;
			"v":  b = 8'h0B;
			"a":  b = 8'h07;
			"e":  b = esd_pkg::BYTE_ESC;
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// -1 when c is not a hex digit
	function automatic int hex_digit(input esd_pkg::byte_t c);
		if (c >= "0" && c <= "9")
			return c - "0";
		if (c >= "a" && c <= "f")
			return c - "a" + 10;
		if (c >= "A" && c <= "F")
			return c - "A" + 10;
		return -1;
	endfunction

	task automatic owe(input esd_pkg::byte_t b, input logic f, input logic bad);
		dec_byte_t d;
		d.data = b;
		d.fin  = f;
		d.bad  = bad;
		bytes_due.push_back(d);
	endtask

	// Advance the parse on one accepted character; on the final one queue the
	// bytes it decodes to and fall back to the idle parse state.
	task automatic decode_char(input esd_pkg::byte_t c, input logic fin);
		esd_pkg::byte_t mapped;
		logic           is_simple;
		logic           simple_hit;
		int             dig;
		simple_hit = 1'b0;
		is_simple  = simple_lookup(c, mapped);
		dig        = hex_digit(c);
		case (mode_q)
			PARSE_START: begin
				if (is_simple) begin
					simple_q   = mapped;
					simple_hit = 1'b1;
					mode_q     = PARSE_BAD;	// anything after it is an error
				end else if (c >= esd_pkg::CH_0 && c <= esd_pkg::CH_7) begin
					mode_q = PARSE_OCT;
					acc_q  = {13'd0, c[2:0]};
					ndig_q = 3'd1;
				end else if (c == esd_pkg::CH_X) begin
					mode_q = PARSE_HEX;
					acc_q  = 16'd0;
					ndig_q = 3'd0;
				end else if (c == esd_pkg::CH_U) begin
					mode_q = PARSE_UNI;
					acc_q  = 16'd0;
					ndig_q = 3'd0;
				end else begin
					mode_q = PARSE_BAD;
				end
			end
			PARSE_OCT: begin
				if (c >= esd_pkg::CH_0 && c <= esd_pkg::CH_7 && ndig_q < 3'd3) begin
					acc_q  = {acc_q[12:0], c[2:0]};
					ndig_q = ndig_q + 3'd1;
				end else begin
					mode_q = PARSE_BAD;
				end
			end
			PARSE_HEX: begin
				if (dig >= 0) begin
					acc_q = {acc_q[11:0], dig[3:0]};
					if (ndig_q < 3'd7)
						ndig_q = ndig_q + 3'd1;	// saturates, only "at least one" matters
				end else begin
					mode_q = PARSE_BAD;
				end
			end
			PARSE_UNI: begin
				if (dig >= 0 && ndig_q < 3'd4) begin
					acc_q  = {acc_q[11:0], dig[3:0]};
					ndig_q = ndig_q + 3'd1;
				end else begin
					mode_q = PARSE_BAD;
				end
			end
			default: mode_q = PARSE_BAD;
		endcase

		if (!fin)
			return;

		escapes_seen++;
		if (simple_hit) begin
			owe(simple_q, 1'b1, 1'b0);
		end else if (mode_q == PARSE_OCT) begin
			owe(acc_q[7:0], 1'b1, 1'b0);
		end else if (mode_q == PARSE_HEX && ndig_q >= 3'd1) begin
			owe(acc_q[7:0], 1'b1, 1'b0);
		end else if (mode_q == PARSE_UNI && ndig_q == 3'd4 &&
				!(acc_q >= 16'hD800 && acc_q <= 16'hDFFF)) begin
			// UTF-8: one, two or three bytes by code point range
			if (acc_q < 16'h0080) begin
				owe(acc_q[7:0], 1'b1, 1'b0);
			end else if (acc_q < 16'h0800) begin
				owe({3'b110, acc_q[10:6]}, 1'b0, 1'b0);
				owe({2'b10, acc_q[5:0]}, 1'b1, 1'b0);
				multi_seen++;
			end else begin
				owe({4'b1110, acc_q[15:12]}, 1'b0, 1'b0);
				owe({2'b10, acc_q[11:6]}, 1'b0, 1'b0);
				owe({2'b10, acc_q[5:0]}, 1'b1, 1'b0);
				multi_seen++;
			end
		end else begin
			owe(8'h00, 1'b1, 1'b1);
		end

		mode_q   = PARSE_START;
		acc_q    = 16'd0;
		ndig_q   = 3'd0;
		simple_q = 8'h00;
	endtask

	//------------------------------------------------------------------
	// Stimulus helpers
	//------------------------------------------------------------------
	task automatic put_char(input esd_pkg::byte_t c, input logic fin);
		body_item_t it;
		it.ch  = c;
		it.fin = fin;
		chars_to_send.push_back(it);
	endtask

	// Send body_buf as one escape body, last flag on its final character
	task automatic emit_buf();
		foreach (body_buf[i])
			put_char(body_buf[i], i == body_buf.size() - 1);
		body_buf.delete();
	endtask

	task automatic emit_text(input string s);
		for (int i = 0; i < s.len(); i++)
			body_buf.push_back(s[i]);
		emit_buf();
	endtask

	function automatic esd_pkg::byte_t hex_char(input logic [3:0] v, input logic upper);
		if (v < 4'd10)
			return 8'h30 + v;
		return (upper ? "A" : "a") + v - 4'd10;
	endfunction

	task automatic add_hex(input int n);
		for (int i = 0; i < n; i++)
			body_buf.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
	endtask

	task automatic add_octal(input int n);
		for (int i = 0; i < n; i++)
			body_buf.push_back(esd_pkg::CH_0 + 8'($urandom_range(7)));
	endtask

	task automatic add_code_point(input logic [15:0] v);
		body_buf.push_back(esd_pkg::CH_U);
		for (int i = 3; i >= 0; i--)
			body_buf.push_back(hex_char(v[i*4 +: 4], 1'($urandom_range(1))));
	endtask

	// A character that never continues hex or octal digits
	function automatic esd_pkg::byte_t non_digit();
		esd_pkg::byte_t c;
		do
			c = 8'($urandom_range(255));
		while (hex_digit(c) >= 0);
		return c;
	endfunction

	// One random escape body: mostly legal forms with random content,
	// the rest broken forms and raw noise.
	task automatic random_escape();
		int pick;
		int sub;
		logic [15:0] cp;
		pick = $urandom_range(99);
		if (pick < 15) begin
			body_buf.push_back(simple_set[$urandom_range(simple_set.len() - 1)]);
		end else if (pick < 30) begin
			add_octal($urandom_range(1, 3));
		end else if (pick < 45) begin
			body_buf.push_back(esd_pkg::CH_X);
			add_hex(($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4));
		end else if (pick < 70) begin
			sub = $urandom_range(9);
			if (sub < 3)
				cp = 16'($urandom_range(16'h007F));
			else if (sub < 6)
				cp = 16'($urandom_range(16'h0080, 16'h07FF));
			else if (sub < 9)
				cp = 16'($urandom_range(16'h0800, 16'hFFFF));
			else
				cp = 16'($urandom_range(16'hD800, 16'hDFFF));
			add_code_point(cp);
		end else if (pick < 85) begin
			case ($urandom_range(5))
				0: begin	// trailing junk after a simple escape
					body_buf.push_back(simple_set[$urandom_range(simple_set.len() - 1)]);
					body_buf.push_back(8'($urandom_range(255)));
				end
				1: add_octal(4);
				2: begin
					body_buf.push_back(esd_pkg::CH_X);
					add_hex($urandom_range(0, 2));
					if (body_buf.size() > 1 || $urandom_range(1))
						body_buf.push_back(non_digit());
				end
				3: begin
					body_buf.push_back(esd_pkg::CH_U);
					add_hex($urandom_range(1) ? $urandom_range(0, 3) : $urandom_range(5, 6));
				end
				4: begin
					add_code_point(16'($urandom_range(16'hFFFF)));
					body_buf.push_back(8'($urandom_range(255)));
				end
				default: begin	// digits that are not octal
					add_octal($urandom_range(0, 2));
					body_buf.push_back($urandom_range(1) ? "8" : "9");
				end
			endcase
		end else begin
			sub = $urandom_range(1, 3);
			for (int i = 0; i < sub; i++)
				body_buf.push_back(8'($urandom_range(255)));
		end
		emit_buf();
	endtask

	//------------------------------------------------------------------
	// Character driver: presents the next request whenever the current one
	// has gone (or none is up), idling about 22% of the time outside the
	// quiet window. Each accepted character goes through the scoreboard
	// decoder at the edge it is taken.
	//------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			body_ch.valid     <= 1'b0;
			body_ch.body_char <= 8'h00;
			body_ch.body_last <= 1'b0;
		end else begin
			if (body_ch.valid && body_ch.ready) begin
				decode_char(body_ch.body_char, body_ch.body_last);
				chars_taken++;
			end
			if (!body_ch.valid || body_ch.ready) begin
				if (chars_to_send.size() != 0 && (quiet || $urandom_range(99) >= 22)) begin
					body_ch.valid     <= 1'b1;
					body_ch.body_char <= chars_to_send[0].ch;
					body_ch.body_last <= chars_to_send[0].fin;
					void'(chars_to_send.pop_front());
				end else begin
					body_ch.valid <= 1'b0;
				end
			end
		end
	end

	//------------------------------------------------------------------
	// Byte monitor: every accepted output request is compared with the
	// oldest byte still owed. Ready stalls at random like the driver.
	//------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			dec_ch.ready <= 1'b0;
		end else begin
			if (dec_ch.valid && dec_ch.ready) begin
				if (bytes_due.size() == 0) begin
					$display("%0t: unexpected byte: expected none, actual byte=%h last=%b bad=%b",
						$time, dec_ch.out_byte, dec_ch.out_last, dec_ch.bad_escape);
					errors++;
				end else begin
					if (dec_ch.out_byte !== bytes_due[0].data) begin
						$display("%0t: out_byte mismatch: expected %h, actual %h",
							$time, bytes_due[0].data, dec_ch.out_byte);
						errors++;
					end
					if (dec_ch.out_last !== bytes_due[0].fin) begin
						$display("%0t: out_last mismatch: expected %b, actual %b",
							$time, bytes_due[0].fin, dec_ch.out_last);
						errors++;
					end
					if (dec_ch.bad_escape !== bytes_due[0].bad) begin
						$display("%0t: bad_escape mismatch: expected %b, actual %b",
							$time, bytes_due[0].bad, dec_ch.bad_escape);
						errors++;
					end
					void'(bytes_due.pop_front());
				end
				bytes_checked++;
				if (dec_ch.bad_escape === 1'b1)
					bad_checked++;
			end
			dec_ch.ready <= quiet || ($urandom_range(99) >= 22);
		end
	end

	//------------------------------------------------------------------
	// Main sequence: reset, build the stimulus, drain, report
	//------------------------------------------------------------------
	initial begin
		arst_n            = 1'b0;
		body_ch.valid     = 1'b0;
		body_ch.body_char = 8'h00;
		body_ch.body_last = 1'b0;
		dec_ch.ready      = 1'b0;
		errors            = 0;
		chars_taken       = 0;
		escapes_seen      = 0;
		multi_seen        = 0;
		bytes_checked     = 0;
		bad_checked       = 0;
		mode_q            = PARSE_START;
		acc_q             = 16'd0;
		ndig_q            = 3'd0;
		simple_q          = 8'h00;

		// Directed: every simple escape, octal and hex edges, each UTF-8 length,
		// surrogate bounds, wrong digit counts, junk after a simple escape,
		// and the all-zero and all-one raw characters.
		for (int i = 0; i < simple_set.len(); i++)
			emit_text(simple_set.substr(i, i));
		emit_text("0");                  // lone zero is octal
		emit_text("777");                // wraps to low 8 bits
		emit_text("1234");               // fourth octal digit
		emit_text("x");                  // no hex digits
		emit_text("x123456789aBcDeF");   // long hex keeps low bits
		emit_text("xg");
		emit_text("u");
		emit_text("u0000");
		emit_text("u007F");
		emit_text("u0080");
		emit_text("u07FF");
		emit_text("u0800");
		emit_text("uFFFF");
		emit_text("uD800");
		emit_text("uDFFF");
		emit_text("u123");
		emit_text("u12345");
		emit_text("n?");
		emit_text("9");
		put_char(8'hFF, 1'b1);
		put_char(8'h00, 1'b1);

		// random bodies fill the rest up to about 220 characters
		while (chars_to_send.size() < 220)
			random_escape();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all characters taken, all owed bytes seen, then a further
		// wait for anything stray to show up.
		while (chars_to_send.size() != 0 || body_ch.valid)
			@(posedge clk);
		while (bytes_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d escape bodies over %0d characters; %0d bytes checked,",
			escapes_seen, chars_taken, bytes_checked);
		$display("  %0d error results, %0d multi-byte UTF-8 sequences", bad_checked, multi_seen);
		if (errors == 0 && bytes_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
